@@ src/aapr_pkg.sv @@
package aapr_pkg;

	// Input transaction: point, pivot, angle and axis.
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] pivot_x;
		logic signed [31:0] pivot_y;
		logic signed [31:0] pivot_z;
		logic signed [15:0] turn_angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_t;

	// Result transaction: rotated point and saturation flag.
	typedef struct packed {
		logic signed [31:0] rotated_x;
		logic signed [31:0] rotated_y;
		logic signed [31:0] rotated_z;
		logic               clipped;
	} out_t;

	// Data that travels alongside the CORDIC.
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] aa_xx;
		logic signed [31:0] aa_yy;
		logic signed [31:0] aa_zz;
		logic signed [31:0] aa_xy;
		logic signed [31:0] aa_xz;
		logic signed [31:0] aa_yz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} side_t;

	// Rotation matrix, Q.24 entries.
	typedef struct packed {
		logic signed [33:0] m00;
		logic signed [33:0] m01;
		logic signed [33:0] m02;
		logic signed [33:0] m10;
		logic signed [33:0] m11;
		logic signed [33:0] m12;
		logic signed [33:0] m20;
		logic signed [33:0] m21;
		logic signed [33:0] m22;
	} mat_t;

	typedef logic signed [33:0] cw_t;

	localparam int ATAN_LEN = 24;
	localparam cw_t GAIN_Q30 = 34'sd652032874;
	localparam cw_t ONE_Q30 = 34'sd1073741824;
	localparam cw_t ANG_PI = 34'sd1686629713;
	localparam cw_t ANG_HALF_PI = 34'sd843314857;

	// atan(2^-i) in Q.29.
	localparam cw_t ATAN_Q29 [ATAN_LEN] = '{
		34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
		34'sd33510843, 34'sd16771758, 34'sd8387925, 34'sd4194219,
		34'sd2097141, 34'sd1048575, 34'sd524288, 34'sd262144,
		34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384,
		34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024,
		34'sd512, 34'sd256, 34'sd128, 34'sd64
	};

endpackage

@@ src/aapr_cordic.sv @@
module aapr_cordic import aapr_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  cw_t   z_in,
	input  logic  flip_in,
	input  side_t side_in,
	output logic  out_valid,
	output cw_t   sin_out,
	output cw_t   cos_out,
	output side_t side_out
);

	cw_t   x_s [STEPS+1];
	cw_t   y_s [STEPS+1];
	cw_t   z_s [STEPS+1];
	logic  flip_s [STEPS+1];
	side_t side_s [STEPS+1];
	logic  valid_s [STEPS+1];

	// Stage zero is the entry point of the rotation.
	assign x_s[0] = GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = z_in;
	assign flip_s[0] = flip_in;
	assign side_s[0] = side_in;
	assign valid_s[0] = in_valid;

	// One micro-rotation per register stage.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_Q29[i];
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_Q29[i];
			end
			flip_s[i+1] <= flip_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	// Undo the fold by pi.
	assign cos_out = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_out = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	assign side_out = side_s[STEPS];
	assign out_valid = valid_s[STEPS];

endmodule

@@ src/aapr_matrix.sv @@
module aapr_matrix import aapr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  cw_t   sin_in,
	input  cw_t   cos_in,
	input  side_t side_in,
	output logic  out_valid,
	output mat_t  mat_out,
	output side_t side_out
);

	logic               valid_s1, valid_s2, valid_s3;
	cw_t                cs_s1, sn_s1, omc_s1;
	side_t              side_s1, side_s2, side_s3;
	logic signed [31:0] oxx_s2, oyy_s2, ozz_s2, oxy_s2, oxz_s2, oyz_s2;
	logic signed [29:0] kx_s2, ky_s2, kz_s2;
	logic signed [27:0] c6_s2;
	mat_t               mat_s3;
	logic signed [65:0] pxx, pyy, pzz, pxy, pxz, pyz;
	logic signed [49:0] qx, qy, qz;

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Products of (1 - cos) with the axis products and of the axis with sine.
	assign pxx = 66'(omc_s1) * 66'(side_s1.aa_xx);
	assign pyy = 66'(omc_s1) * 66'(side_s1.aa_yy);
	assign pzz = 66'(omc_s1) * 66'(side_s1.aa_zz);
	assign pxy = 66'(omc_s1) * 66'(side_s1.aa_xy);
	assign pxz = 66'(omc_s1) * 66'(side_s1.aa_xz);
	assign pyz = 66'(omc_s1) * 66'(side_s1.aa_yz);
	assign qx = 50'(side_s1.ax) * 50'(sn_s1);
	assign qy = 50'(side_s1.ay) * 50'(sn_s1);
	assign qz = 50'(side_s1.az) * 50'(sn_s1);

	always_ff @(posedge clk) begin
		// First stage: register sine, cosine and 1 - cos.
		cs_s1 <= cos_in;
		sn_s1 <= sin_in;
		omc_s1 <= ONE_Q30 - cos_in;
		side_s1 <= side_in;
		// Second stage: scaled terms, floor shifts by part-select.
		oxx_s2 <= pxx[65:34];
		oyy_s2 <= pyy[65:34];
		ozz_s2 <= pzz[65:34];
		oxy_s2 <= pxy[65:34];
		oxz_s2 <= pxz[65:34];
		oyz_s2 <= pyz[65:34];
		kx_s2 <= qx[49:20];
		ky_s2 <= qy[49:20];
		kz_s2 <= qz[49:20];
		c6_s2 <= cs_s1[33:6];
		side_s2 <= side_s1;
		// Third stage: assemble the Rodrigues matrix.
		mat_s3.m00 <= 34'(c6_s2) + 34'(oxx_s2);
		mat_s3.m11 <= 34'(c6_s2) + 34'(oyy_s2);
		mat_s3.m22 <= 34'(c6_s2) + 34'(ozz_s2);
		mat_s3.m01 <= 34'(oxy_s2) - 34'(kz_s2);
		mat_s3.m02 <= 34'(oxz_s2) + 34'(ky_s2);
		mat_s3.m10 <= 34'(oxy_s2) + 34'(kz_s2);
		mat_s3.m12 <= 34'(oyz_s2) - 34'(kx_s2);
		mat_s3.m20 <= 34'(oxz_s2) - 34'(ky_s2);
		mat_s3.m21 <= 34'(oyz_s2) + 34'(kx_s2);
		side_s3 <= side_s2;
	end

	assign out_valid = valid_s3;
	assign mat_out = mat_s3;
	assign side_out = side_s3;

endmodule

@@ src/aapr_xform.sv @@
module aapr_xform import aapr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  mat_t  mat_in,
	input  side_t side_in,
	output logic  out_valid,
	output out_t  result_out
);

	localparam logic signed [42:0] MAX32 = 43'sd2147483647;
	localparam logic signed [42:0] MIN32 = -43'sd2147483648;

	logic               valid_s1, valid_s2;
	logic signed [65:0] p_s1 [9];
	side_t              side_s1;
	out_t               res_s2;
	logic signed [65:0] acc [3];
	logic signed [42:0] sum [3];
	logic signed [31:0] piv [3];
	logic signed [31:0] sat [3];
	logic [2:0]         hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// First stage: the nine matrix-vector products.
	always_ff @(posedge clk) begin
		p_s1[0] <= 66'(mat_in.m00) * 66'(side_in.dx);
		p_s1[1] <= 66'(mat_in.m01) * 66'(side_in.dy);
		p_s1[2] <= 66'(mat_in.m02) * 66'(side_in.dz);
		p_s1[3] <= 66'(mat_in.m10) * 66'(side_in.dx);
		p_s1[4] <= 66'(mat_in.m11) * 66'(side_in.dy);
		p_s1[5] <= 66'(mat_in.m12) * 66'(side_in.dz);
		p_s1[6] <= 66'(mat_in.m20) * 66'(side_in.dx);
		p_s1[7] <= 66'(mat_in.m21) * 66'(side_in.dy);
		p_s1[8] <= 66'(mat_in.m22) * 66'(side_in.dz);
		side_s1 <= side_in;
	end

	assign piv[0] = side_s1.px;
	assign piv[1] = side_s1.py;
	assign piv[2] = side_s1.pz;

	// Second stage: row sums, rescale, add the pivot back and saturate.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = p_s1[3*k] + p_s1[3*k+1] + p_s1[3*k+2];
			sum[k] = 43'($signed(acc[k][65:24])) + 43'(piv[k]);
			if (sum[k] > MAX32) begin
				sat[k] = MAX32[31:0];
				hit[k] = 1'b1;
			end else if (sum[k] < MIN32) begin
				sat[k] = MIN32[31:0];
				hit[k] = 1'b1;
			end else begin
				sat[k] = sum[k][31:0];
				hit[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2.rotated_x <= sat[0];
		res_s2.rotated_y <= sat[1];
		res_s2.rotated_z <= sat[2];
		res_s2.clipped <= |hit;
	end

	assign out_valid = valid_s2;
	assign result_out = res_s2;

endmodule

@@ src/axis_angle_point_rotation_unit.sv @@
// Axis-angle point rotation unit.
// A transaction is accepted on a rising edge with start high and busy low.
// The operand carries the point, the pivot, a Q2.13 angle and a Q1.14 axis
// that is taken as unit length. The block rotates the point about the axis
// through the pivot and returns the Q16.16 result, saturated, with clipped
// set when any coordinate hit a bound.
// busy is always low: the datapath is fully pipelined and takes one new
// transaction every cycle, with no carried state between transactions.
// From accept to done a transaction passes one input stage, one CORDIC stage
// per step, min(CORDIC_STEPS, 24) in all, three matrix and two transform
// stages. done is high for exactly one cycle with the result; the receiver
// cannot stall, so the result must be taken in that cycle.
// Reset clears every valid bit so no spurious done follows it; transactions
// in flight at reset are dropped.
module axis_angle_point_rotation_unit import aapr_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  operand,
	output logic done,
	output out_t result
);

	localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int LAT = NSTEPS + 6;

	logic  valid_s1;
	cw_t   z_s1;
	logic  flip_s1;
	side_t side_s1;
	cw_t   z_wide;
	logic  cv, mv;
	cw_t   sn, cs;
	side_t side_c, side_m;
	mat_t  mat;

	assign busy = 1'b0;

	// Angle widened to Q.29.
	assign z_wide = {{2{operand.turn_angle[15]}}, operand.turn_angle, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Input stage: differences, angle fold and axis products.
	always_ff @(posedge clk) begin
		if (z_wide > ANG_HALF_PI) begin
			z_s1 <= z_wide - ANG_PI;
			flip_s1 <= 1'b1;
		end else if (z_wide < -ANG_HALF_PI) begin
			z_s1 <= z_wide + ANG_PI;
			flip_s1 <= 1'b1;
		end else begin
			z_s1 <= z_wide;
			flip_s1 <= 1'b0;
		end
		side_s1.dx <= 33'(operand.point_x) - 33'(operand.pivot_x);
		side_s1.dy <= 33'(operand.point_y) - 33'(operand.pivot_y);
		side_s1.dz <= 33'(operand.point_z) - 33'(operand.pivot_z);
		side_s1.px <= operand.pivot_x;
		side_s1.py <= operand.pivot_y;
		side_s1.pz <= operand.pivot_z;
		side_s1.aa_xx <= 32'(operand.axis_x) * 32'(operand.axis_x);
		side_s1.aa_yy <= 32'(operand.axis_y) * 32'(operand.axis_y);
		side_s1.aa_zz <= 32'(operand.axis_z) * 32'(operand.axis_z);
		side_s1.aa_xy <= 32'(operand.axis_x) * 32'(operand.axis_y);
		side_s1.aa_xz <= 32'(operand.axis_x) * 32'(operand.axis_z);
		side_s1.aa_yz <= 32'(operand.axis_y) * 32'(operand.axis_z);
		side_s1.ax <= operand.axis_x;
		side_s1.ay <= operand.axis_y;
		side_s1.az <= operand.axis_z;
	end

	aapr_cordic #(.STEPS(NSTEPS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.z_in     (z_s1),
		.flip_in  (flip_s1),
		.side_in  (side_s1),
		.out_valid(cv),
		.sin_out  (sn),
		.cos_out  (cs),
		.side_out (side_c)
	);

	aapr_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv),
		.sin_in   (sn),
		.cos_in   (cs),
		.side_in  (side_c),
		.out_valid(mv),
		.mat_out  (mat),
		.side_out (side_m)
	);

	aapr_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mv),
		.mat_in    (mat),
		.side_in   (side_m),
		.out_valid (done),
		.result_out(result)
	);

	// Every result comes from a transaction accepted a fixed latency earlier.
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a matching start");

	// A clipped result sits on a bound in at least one coordinate.
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.clipped) |->
		(result.rotated_x == 32'sh7fffffff || result.rotated_x == 32'sh80000000 ||
		 result.rotated_y == 32'sh7fffffff || result.rotated_y == 32'sh80000000 ||
		 result.rotated_z == 32'sh7fffffff || result.rotated_z == 32'sh80000000))
		else $error("clipped set without a saturated coordinate");

endmodule

@@ tb/tb.sv @@
module tb;
	import aapr_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = ((STEPS < 24) ? STEPS : 24) + 6;
	localparam int N_RANDOM = 1330;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  operand;
	logic done;
	out_t result;

	in_t  pending_q[$];
	out_t rotated_q[$];
	int   n_errors;
	bit   feeding_done;

	axis_angle_point_rotation_unit #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand(operand),
		.done(done),
		.result(result)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Floor shift on 64-bit signed values.
	function automatic longint shr_fl(input longint v, input int s);
		return v >>> s;
	endfunction

	// Predicts the rotated point for one transaction.
	function automatic out_t rotate_point(input in_t t);
		longint z, x, y, dx, dy, sn, cs, omc, oxy, oxz, oyz, acc, r, nst;
		longint d[3], c[3], a[3], m[3][3];
		bit flip;
		out_t o;
		longint atab[24];
		atab = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
			8387925, 4194219, 2097141, 1048575, 524288, 262144,
			131072, 65536, 32768, 16384, 8192, 4096,
			2048, 1024, 512, 256, 128, 64};
		c[0] = longint'(t.pivot_x);
		c[1] = longint'(t.pivot_y);
		c[2] = longint'(t.pivot_z);
		d[0] = longint'(t.point_x) - c[0];
		d[1] = longint'(t.point_y) - c[1];
		d[2] = longint'(t.point_z) - c[2];
		a[0] = longint'(t.axis_x);
		a[1] = longint'(t.axis_y);
		a[2] = longint'(t.axis_z);
		// Fold the angle into the CORDIC range, then iterate.
		z = longint'(t.turn_angle) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 843314857) begin
			z -= 1686629713;
			flip = 1;
		end else if (z < -843314857) begin
			z += 1686629713;
			flip = 1;
		end
		nst = (STEPS < 24) ? STEPS : 24;
		for (int i = 0; i < nst; i++) begin
			dx = shr_fl(y, i);
			dy = shr_fl(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atab[i];
			end else begin
				x += dx; y -= dy; z += atab[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		sn = y;
		cs = x;
		omc = 64'sd1073741824 - cs;
		// Rodrigues matrix in Q.24.
		oxy = shr_fl(omc * a[0] * a[1], 34);
		oxz = shr_fl(omc * a[0] * a[2], 34);
		oyz = shr_fl(omc * a[1] * a[2], 34);
		for (int k = 0; k < 3; k++)
			m[k][k] = shr_fl(cs, 6) + shr_fl(omc * a[k] * a[k], 34);
		m[0][1] = oxy - shr_fl(a[2] * sn, 20);
		m[0][2] = oxz + shr_fl(a[1] * sn, 20);
		m[1][0] = oxy + shr_fl(a[2] * sn, 20);
		m[1][2] = oyz - shr_fl(a[0] * sn, 20);
		m[2][0] = oxz - shr_fl(a[1] * sn, 20);
		m[2][1] = oyz + shr_fl(a[0] * sn, 20);
		o.clipped = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = m[k][0] * d[0] + m[k][1] * d[1] + m[k][2] * d[2];
			r = shr_fl(acc, 24) + c[k];
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
				o.clipped = 1'b1;
			end else if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
				o.clipped = 1'b1;
			end
			case (k)
				0: o.rotated_x = r[31:0];
				1: o.rotated_y = r[31:0];
				default: o.rotated_z = r[31:0];
			endcase
		end
		return o;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
		endcase
	endfunction

	// An axis with each component within +-1/sqrt(3), so of at most unit length, or any code now and then.
	function automatic in_t rand_item();
		in_t t;
		int sel;
		t.point_x = rand_coord();
		t.point_y = rand_coord();
		t.point_z = rand_coord();
		t.pivot_x = rand_coord();
		t.pivot_y = rand_coord();
		t.pivot_z = rand_coord();
		t.turn_angle = 16'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			t.axis_x = 16'($urandom);
			t.axis_y = 16'($urandom);
			t.axis_z = 16'($urandom);
		end else begin
			t.axis_x = 16'($signed($urandom_range(0, 18918)) - 9459);
			t.axis_y = 16'($signed($urandom_range(0, 18918)) - 9459);
			t.axis_z = 16'($signed($urandom_range(0, 18918)) - 9459);
		end
		return t;
	endfunction

	// Stimulus: directed corners, then random transactions.
	initial begin
		in_t t;
		logic signed [15:0] ang[10];
		ang = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sd12868, -16'sd12868,
			16'sd12869, -16'sd12869, 16'sd25736, 16'sd6434, -16'sd6434};
		for (int i = 0; i < 10; i++) begin
			t = '0;
			t.point_x = 32'sh00010000;
			t.point_y = 32'sh00020000;
			t.point_z = -32'sh00030000;
			t.pivot_x = 32'sh00008000;
			t.turn_angle = ang[i];
			t.axis_x = (i % 3 == 0) ? 16'sd16384 : 16'sd0;
			t.axis_y = (i % 3 == 1) ? 16'sd16384 : 16'sd0;
			t.axis_z = (i % 3 == 2) ? -16'sd16384 : 16'sd0;
			pending_q.push_back(t);
		end
		// Saturation in both directions, extreme axis codes.
		t = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 16'sd12868, 16'h7fff, 16'h7fff, 16'h7fff};
		pending_q.push_back(t);
		t = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, -16'sd25000, 16'h8000, 16'h8000, 16'h8000};
		pending_q.push_back(t);
		t = '{32'hffffffff, 32'h0, 32'h7fffffff, 32'h0, 32'hffffffff,
			32'h80000000, 16'hffff, 16'hffff, 16'h0, 16'h8000};
		pending_q.push_back(t);
		t = '1;
		pending_q.push_back(t);
		t = '0;
		pending_q.push_back(t);
		for (int i = 0; i < N_RANDOM; i++)
			pending_q.push_back(rand_item());
		feeding_done = 1'b1;
	end

	// Driver: presents transactions with occasional idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operand <= '0;
		end else begin
			// The presented transaction leaves the queue once it is accepted.
			if (start && !busy) begin
				rotated_q.push_back(rotate_point(operand));
				void'(pending_q.pop_front());
			end
			if (pending_q.size() > 0 &&
				(($urandom_range(0, 99) >= 8) ||
				(pending_q.size() > 300 && pending_q.size() < 700))) begin
				operand <= pending_q[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compares every result with the oldest prediction.
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				n_errors++;
			end else begin
				exp_r = rotated_q.pop_front();
				if (result.rotated_x !== exp_r.rotated_x) begin
					$display("%0t: rotated_x expected %h actual %h", $time,
						exp_r.rotated_x, result.rotated_x);
					n_errors++;
				end
				if (result.rotated_y !== exp_r.rotated_y) begin
					$display("%0t: rotated_y expected %h actual %h", $time,
						exp_r.rotated_y, result.rotated_y);
					n_errors++;
				end
				if (result.rotated_z !== exp_r.rotated_z) begin
					$display("%0t: rotated_z expected %h actual %h", $time,
						exp_r.rotated_z, result.rotated_z);
					n_errors++;
				end
				if (result.clipped !== exp_r.clipped) begin
					$display("%0t: clipped expected %b actual %b", $time,
						exp_r.clipped, result.clipped);
					n_errors++;
				end
			end
		end
	end

	// Reset, then wait for the stimulus to drain and every result to arrive.
	initial begin
		n_errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operand = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (feeding_done);
		while (pending_q.size() != 0 || start) @(posedge clk);
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0 && rotated_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#500000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/aapr_pkg.sv
src/aapr_cordic.sv
src/aapr_matrix.sv
src/aapr_xform.sv
src/axis_angle_point_rotation_unit.sv
tb/tb.sv
